FILE: sv/acsc_pkg.sv
// ----------------------------------------------------------------------------
// acsc_pkg
// Shared types and constants of the actuator sample cycle controller.
// ----------------------------------------------------------------------------
`default_nettype none

package acsc_pkg;

    // position counter width and dial scaling ceilings
    localparam int POS_W      = 16;
    localparam int DIAL_W     = 10;
    localparam int SPEED_W    = 8;
    localparam int DIST_W     = 10;
    localparam int TIMER_W    = 10;
    localparam int MAX_SPEED  = 200;
    localparam int MAX_TRAVEL = 950;

    // stream payload widths
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 10;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_RET_FLOOR      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HOME_THRESHOLD = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RETREAT_DUTY   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PAUSE_TICKS    = 2'd3;

    // register reset values
    localparam logic [DIST_W-1:0]  RET_FLOOR_RST      = 10'd10;
    localparam logic [DIST_W-1:0]  HOME_THRESHOLD_RST = 10'd5;
    localparam logic [SPEED_W-1:0] RETREAT_DUTY_RST   = 8'd70;
    localparam logic [TIMER_W-1:0] PAUSE_TICKS_RST    = 10'd500;

    // led codes
    localparam logic [2:0] LED_BLINK_OFF = 3'b000;
    localparam logic [2:0] LED_GREEN     = 3'b001;
    localparam logic [2:0] LED_BLINK_ON  = 3'b001;
    localparam logic [2:0] LED_YELLOW    = 3'b010;
    localparam logic [2:0] LED_WAIT      = 3'b100;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_FWD     = 3'd1,
        MODE_RET     = 3'd2,
        MODE_PAUSE   = 3'd3,
        MODE_RETREAT = 3'd4,
        MODE_WAIT    = 3'd5
    } t_mode;

    typedef struct packed {
        logic [DIST_W-1:0]  ret_floor;
        logic [DIST_W-1:0]  home_threshold;
        logic [SPEED_W-1:0] retreat_duty;
        logic [TIMER_W-1:0] pause_ticks;
    } t_cfg;

    typedef struct packed {
        logic              enc_rise;
        logic              enc_b_level;
        logic              estop_press;
        logic              sample_press;
        logic [DIAL_W-1:0] speed_dial;
        logic [DIAL_W-1:0] distance_dial;
    } t_tick;

    typedef struct packed {
        logic [7:0]       pwm_right;
        logic [7:0]       pwm_left;
        logic [2:0]       led_code;
        logic [2:0]       mode_code;
        logic [POS_W-1:0] position;
    } t_result;

endpackage

`default_nettype wire

FILE: sv/actuator_sample_cycle_controller_unit.sv
// ----------------------------------------------------------------------------
// actuator_sample_cycle_controller_unit
// Sample-arm motor controller: one tick item in, one status result out.
//
// channel   dir  handshake            payload
// s_axis    in   tvalid / tready      tick: encoder, buttons, two dials
// m_axis    out  tvalid / tready      pwm duties, led, mode, position
// cfg       in   we (no wait)         addr selects one of four registers
//
// The input register takes the item at the transfer edge; one pass of the step
// logic fills the result register when the input stage advances.
// One item per cycle is sustained unless the result stalls; the step logic
// and state update once per item. A stalled result holds both stages, input
// is still taken while the input register is free. Reset is synchronous; it
// clears the valid flags and the controller state and reloads the register
// defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module actuator_sample_cycle_controller_unit
    import acsc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // fields from bit 0: enc_rise, enc_b_level, estop_press, sample_press,
    // speed_dial[9:0], distance_dial[9:0]
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // fields from bit 0: pwm_right[7:0], pwm_left[7:0], led_code[2:0],
    // mode_code[2:0], position[15:0], two zero pad bits
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg                  r_cfg;
    logic                  r_in_valid;
    logic [IN_DATA_W-1:0]  r_in_data;
    logic                  r_out_valid;
    t_result               r_out;
    t_tick                 tick;
    t_result               step_result;
    logic                  advance;
    logic                  in_xfer;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ret_floor      <= RET_FLOOR_RST;
            r_cfg.home_threshold <= HOME_THRESHOLD_RST;
            r_cfg.retreat_duty   <= RETREAT_DUTY_RST;
            r_cfg.pause_ticks    <= PAUSE_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_RET_FLOOR:      r_cfg.ret_floor      <= i_cfg_wdata[DIST_W-1:0];
                REG_HOME_THRESHOLD: r_cfg.home_threshold <= i_cfg_wdata[DIST_W-1:0];
                REG_RETREAT_DUTY:   r_cfg.retreat_duty   <= i_cfg_wdata[SPEED_W-1:0];
                REG_PAUSE_TICKS:    r_cfg.pause_ticks    <= i_cfg_wdata[TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake: the input stage moves when the result stage is free
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_xfer || (r_in_valid && !advance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_data <= i_s_axis_tdata;
        end
    end

    // unpack the tick
    always_comb begin
        tick.enc_rise      = r_in_data[0];
        tick.enc_b_level   = r_in_data[1];
        tick.estop_press   = r_in_data[2];
        tick.sample_press  = r_in_data[3];
        tick.speed_dial    = r_in_data[4 +: DIAL_W];
        tick.distance_dial = r_in_data[4 + DIAL_W +: DIAL_W];
    end

    acsc_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_tick   (tick),
        .i_cfg    (r_cfg),
        .o_result (step_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= advance || (r_out_valid && !i_m_axis_tready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out.position, r_out.mode_code, r_out.led_code,
                              r_out.pwm_left, r_out.pwm_right};

`ifndef SYNTH
    // the motor is never driven both ways at once
    a_pwm_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.pwm_right == 8'd0 || r_out.pwm_left == 8'd0))
        else $error("both pwm outputs active");

    // forward duty only in forward mode
    a_fwd_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.mode_code != MODE_FWD) |-> r_out.pwm_right == 8'd0)
        else $error("forward pwm outside forward mode");

    // an item leaving the input stage lands in the result register
    a_advance_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("result lost after advance");

    // a waiting result blocks the input stage from moving
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |-> !advance)
        else $error("input stage moved over a stalled result");
`endif

endmodule

`default_nettype wire

FILE: sv/acsc_scale.sv
// ----------------------------------------------------------------------------
// acsc_scale
// Scales the raw dial readings to speed and travel by floor(x*max/1023).
// ----------------------------------------------------------------------------
`default_nettype none

module acsc_scale
    import acsc_pkg::*;
(
    input  wire logic [DIAL_W-1:0]  i_speed_dial,
    input  wire logic [DIAL_W-1:0]  i_distance_dial,
    output logic      [SPEED_W-1:0] o_speed,
    output logic      [DIST_W-1:0]  o_distance
);

    localparam int SPD_PROD_W  = 18;
    localparam int DIST_PROD_W = 20;

    logic [SPD_PROD_W-1:0]  spd_prod;
    logic [SPD_PROD_W-1:0]  spd_sum;
    logic [DIST_PROD_W-1:0] dist_prod;
    logic [DIST_PROD_W-1:0] dist_sum;

    // divide by 1023 as (p + p/1024 + 1) / 1024, exact for these ranges
    always_comb begin
        spd_prod   = SPD_PROD_W'(i_speed_dial) * SPD_PROD_W'(MAX_SPEED);
        spd_sum    = spd_prod + (spd_prod >> DIAL_W) + SPD_PROD_W'(1);
        o_speed    = spd_sum[DIAL_W +: SPEED_W];
        dist_prod  = DIST_PROD_W'(i_distance_dial) * DIST_PROD_W'(MAX_TRAVEL);
        dist_sum   = dist_prod + (dist_prod >> DIAL_W) + DIST_PROD_W'(1);
        o_distance = dist_sum[DIAL_W +: DIST_W];
    end

endmodule

`default_nettype wire

FILE: sv/acsc_step.sv
// ----------------------------------------------------------------------------
// acsc_step
// Controller state and the per-tick mode, position and timer update.
// ----------------------------------------------------------------------------
`default_nettype none

module acsc_step
    import acsc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_en,
    input  wire t_tick   i_tick,
    input  wire t_cfg    i_cfg,
    output t_result      o_result
);

    t_mode                     r_mode,  n_mode;
    logic signed [POS_W-1:0]   r_pos,   n_pos;
    logic [SPEED_W-1:0]        r_speed, n_speed;
    logic [DIST_W-1:0]         r_dist,  n_dist;
    logic [TIMER_W-1:0]        r_timer, n_timer;
    logic                      r_blink, n_blink;

    logic [SPEED_W-1:0]        scaled_speed;
    logic [DIST_W-1:0]         scaled_dist;
    logic [TIMER_W-1:0]        timer_inc;
    logic [7:0]                pwm_r;
    logic [7:0]                pwm_l;
    logic [2:0]                led;

    acsc_scale u_scale (
        .i_speed_dial    (i_tick.speed_dial),
        .i_distance_dial (i_tick.distance_dial),
        .o_speed         (scaled_speed),
        .o_distance      (scaled_dist)
    );

    // next state for one tick
    always_comb begin
        n_mode    = r_mode;
        n_timer   = r_timer;
        n_blink   = r_blink;
        n_speed   = r_speed;
        n_dist    = r_dist;
        timer_inc = r_timer + TIMER_W'(1);
        pwm_r     = '0;
        pwm_l     = '0;
        led       = LED_GREEN;

        // encoder count, wraps
        n_pos = r_pos;
        if (i_tick.enc_rise) begin
            n_pos = i_tick.enc_b_level ? r_pos + POS_W'(1) : r_pos - POS_W'(1);
        end

        // dials tracked while idle
        if (r_mode == MODE_IDLE) begin
            n_speed = scaled_speed;
            n_dist  = scaled_dist;
        end

        // e-stop first
        if (i_tick.estop_press) begin
            unique case (r_mode) inside
                MODE_IDLE: n_mode = MODE_WAIT;
                MODE_WAIT: n_mode = MODE_IDLE;
                MODE_FWD, MODE_RET: begin
                    n_mode  = MODE_PAUSE;
                    n_timer = '0;
                end
                default: ;
            endcase
        end

        // sample press only starts from idle
        if (i_tick.sample_press && n_mode == MODE_IDLE) begin
            n_mode = MODE_FWD;
        end

        // mode's own step when no button moved it
        if (n_mode == r_mode) begin
            unique case (r_mode)
                MODE_FWD: begin
                    if (n_pos > $signed(POS_W'(r_dist))) n_mode = MODE_RET;
                end
                MODE_RET: begin
                    if (n_pos < $signed(POS_W'(i_cfg.ret_floor))) n_mode = MODE_IDLE;
                end
                MODE_PAUSE: begin
                    if (r_timer >= i_cfg.pause_ticks) begin
                        n_mode  = MODE_RETREAT;
                        n_timer = '0;
                        n_blink = 1'b0;
                    end else begin
                        n_timer = timer_inc;
                    end
                end
                MODE_RETREAT: begin
                    if (n_pos <= $signed(POS_W'(i_cfg.home_threshold))) begin
                        n_mode = MODE_WAIT;
                    end else if (timer_inc >= i_cfg.pause_ticks) begin
                        n_timer = '0;
                        n_blink = ~r_blink;
                    end else begin
                        n_timer = timer_inc;
                    end
                end
                default: ;
            endcase
        end

        // outputs follow the mode at the end of the tick
        unique case (n_mode)
            MODE_FWD: begin
                pwm_r = n_speed;
                led   = LED_YELLOW;
            end
            MODE_RET: begin
                pwm_l = n_speed;
                led   = LED_YELLOW;
            end
            MODE_PAUSE:   led = LED_YELLOW;
            MODE_RETREAT: begin
                pwm_l = i_cfg.retreat_duty;
                led   = n_blink ? LED_BLINK_ON : LED_BLINK_OFF;
            end
            MODE_WAIT:    led = LED_WAIT;
            default:      led = LED_GREEN;
        endcase

        o_result.pwm_right = pwm_r;
        o_result.pwm_left  = pwm_l;
        o_result.led_code  = led;
        o_result.mode_code = n_mode;
        o_result.position  = n_pos;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_pos   <= '0;
            r_speed <= '0;
            r_dist  <= '0;
            r_timer <= '0;
            r_blink <= 1'b0;
        end else if (i_en) begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_speed <= n_speed;
            r_dist  <= n_dist;
            r_timer <= n_timer;
            r_blink <= n_blink;
        end
    end

endmodule

`default_nettype wire

FILE: bench/tb_actuator_sample_cycle_controller_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_actuator_sample_cycle_controller_unit
// Self-checking bench for the sample-arm motor controller. Tick items are
// streamed in with random gaps and results drained with random stalls. A
// tracker class predicts pwm, led, mode and position per tick and compares
// every result in order. Directed ticks walk the special cases first, then
// random sample cycles run under several register settings, extremes included.
// ----------------------------------------------------------------------------

module tb_actuator_sample_cycle_controller_unit;
    import acsc_pkg::*;

    // predicted controller state and the status results still owed
    class status_tracker;
        logic [DIST_W-1:0]  min_dist;
        logic [DIST_W-1:0]  home_thr;
        logic [SPEED_W-1:0] retreat_duty;
        logic [TIMER_W-1:0] pause_len;

        t_mode              mode;
        logic [POS_W-1:0]   pos;
        logic [SPEED_W-1:0] duty;
        logic [DIST_W-1:0]  travel;
        logic [TIMER_W-1:0] timer;
        logic               blink;

        t_result expected_status[$];
        int errors;
        int ticks;
        int compared;
        int estop_stops;
        int retreats_done;

        function new();
            min_dist      = RET_FLOOR_RST;
            home_thr      = HOME_THRESHOLD_RST;
            retreat_duty  = RETREAT_DUTY_RST;
            pause_len     = PAUSE_TICKS_RST;
            mode          = MODE_IDLE;
            pos           = '0;
            duty          = '0;
            travel        = '0;
            timer         = '0;
            blink         = 1'b0;
            errors        = 0;
            ticks         = 0;
            compared      = 0;
            estop_stops   = 0;
            retreats_done = 0;
        endfunction

        // advance the controller by one accepted tick
        function void note_tick(logic [IN_DATA_W-1:0] d);
            logic              rise;
            logic              blev;
            logic              estop;
            logic              spress;
            logic [DIAL_W-1:0] sdial;
            logic [DIAL_W-1:0] ddial;
            t_mode             start_mode;
            t_result           r;
            int                p;
            rise   = d[0];
            blev   = d[1];
            estop  = d[2];
            spress = d[3];
            sdial  = d[13:4];
            ddial  = d[23:14];
            ticks++;

            if (rise) pos = blev ? pos + 1'b1 : pos - 1'b1;
            p = $signed(pos);

            // dials only latch while idle
            if (mode == MODE_IDLE) begin
                duty   = SPEED_W'((int'(sdial) * MAX_SPEED) / 1023);
                travel = DIST_W'((int'(ddial) * MAX_TRAVEL) / 1023);
            end

            // buttons first, e-stop before sample
            start_mode = mode;
            if (estop) begin
                case (mode)
                    MODE_IDLE: mode = MODE_WAIT;
                    MODE_WAIT: mode = MODE_IDLE;
                    MODE_FWD, MODE_RET: begin
                        mode = MODE_PAUSE;
                        timer = '0;
                        estop_stops++;
                    end
                    default: ;
                endcase
            end
            if (spress && mode == MODE_IDLE) mode = MODE_FWD;

            // mode step only when no button moved the mode
            if (mode == start_mode) begin
                case (mode)
                    MODE_FWD: if (p > int'(travel)) mode = MODE_RET;
                    MODE_RET: if (p < int'(min_dist)) mode = MODE_IDLE;
                    MODE_PAUSE: begin
                        if (timer >= pause_len) begin
                            mode  = MODE_RETREAT;
                            timer = '0;
                            blink = 1'b0;
                        end else begin
                            timer = timer + 1'b1;
                        end
                    end
                    MODE_RETREAT: begin
                        if (p <= int'(home_thr)) begin
                            mode = MODE_WAIT;
                            retreats_done++;
                        end else begin
                            timer = timer + 1'b1;
                            if (timer >= pause_len) begin
                                timer = '0;
                                blink = ~blink;
                            end
                        end
                    end
                    default: ;
                endcase
            end

            // outputs follow the final mode
            r = '0;
            case (mode)
                MODE_FWD: begin
                    r.pwm_right = duty;
                    r.led_code  = LED_YELLOW;
                end
                MODE_RET: begin
                    r.pwm_left = duty;
                    r.led_code = LED_YELLOW;
                end
                MODE_PAUSE: r.led_code = LED_YELLOW;
                MODE_RETREAT: begin
                    r.pwm_left = retreat_duty;
                    r.led_code = blink ? LED_BLINK_ON : LED_BLINK_OFF;
                end
                MODE_WAIT: r.led_code = LED_WAIT;
                default: r.led_code = LED_GREEN;
            endcase
            r.mode_code = mode;
            r.position  = pos;
            expected_status.push_back(r);
        endfunction

        function void compare_field(string name, int exp_v, int act_v);
            if (exp_v != act_v) begin
                $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        // compare one result transfer with the oldest prediction
        function void check_status(logic [OUT_DATA_W-1:0] d);
            t_result e;
            if (expected_status.size() == 0) begin
                $error("status result 0x%h arrived with no tick pending", d);
                errors++;
                return;
            end
            e = expected_status.pop_front();
            compared++;
            compare_field("pwm_right", e.pwm_right, d[7:0]);
            compare_field("pwm_left", e.pwm_left, d[15:8]);
            compare_field("led_code", e.led_code, d[18:16]);
            compare_field("mode_code", e.mode_code, d[21:19]);
            compare_field("position", $signed(e.position), $signed(d[37:22]));
            compare_field("pad", 0, d[39:38]);
        endfunction
    endclass

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_valid  = 1'b0;
    logic [IN_DATA_W-1:0]  s_data   = '0;
    logic                  m_ready  = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    wire                   s_ready;
    wire                   m_valid;
    wire  [OUT_DATA_W-1:0] m_data;

    status_tracker sb;
    int src_gap_max    = 6;
    int sink_stall_max = 6;
    int stall_left     = 0;
    int n_settings     = 0;

    actuator_sample_cycle_controller_unit i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // result side: random stall after each transfer
    always @(negedge clk) begin
        m_ready <= (stall_left == 0);
    end

    always @(posedge clk) begin
        if (rst_n && m_valid && m_ready) begin
            sb.check_status(m_data);
            stall_left <= $urandom_range(0, sink_stall_max);
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack_tick(logic rise, logic blev, logic estop,
                                                       logic spress, logic [DIAL_W-1:0] sdial,
                                                       logic [DIAL_W-1:0] ddial);
        return {ddial, sdial, spress, estop, blev, rise};
    endfunction

    // random tick shaped by the predicted mode so that cycles complete
    function automatic logic [IN_DATA_W-1:0] next_tick();
        logic              rise;
        logic              blev;
        logic              estop;
        logic              spress;
        logic [DIAL_W-1:0] sdial;
        logic [DIAL_W-1:0] ddial;
        sdial  = DIAL_W'($urandom_range(0, 1023));
        ddial  = ($urandom_range(0, 49) == 0) ? DIAL_W'($urandom_range(0, 1023))
                                              : DIAL_W'($urandom_range(0, 40));
        rise   = $urandom_range(0, 1) == 1;
        blev   = $urandom_range(0, 1) == 1;
        estop  = $urandom_range(0, 11) == 0;
        spress = $urandom_range(0, 2) == 0;
        case (sb.mode)
            MODE_FWD: begin
                rise   = $urandom_range(0, 9) != 0;
                blev   = $urandom_range(0, 9) != 0;
                estop  = $urandom_range(0, 24) == 0;
                spress = $urandom_range(0, 7) == 0;
            end
            MODE_RET: begin
                rise   = $urandom_range(0, 9) != 0;
                blev   = $urandom_range(0, 9) == 0;
                estop  = $urandom_range(0, 24) == 0;
                spress = $urandom_range(0, 7) == 0;
            end
            MODE_PAUSE: begin
                rise  = $urandom_range(0, 2) == 0;
                estop = $urandom_range(0, 5) == 0;
            end
            MODE_RETREAT: begin
                rise  = $urandom_range(0, 6) != 0;
                blev  = $urandom_range(0, 6) == 0;
                estop = $urandom_range(0, 5) == 0;
            end
            MODE_WAIT: begin
                estop  = $urandom_range(0, 3) == 0;
                spress = $urandom_range(0, 3) == 0;
            end
            default: ;
        endcase
        // occasional noise tick
        if ($urandom_range(0, 19) == 0) begin
            rise   = $urandom_range(0, 1) == 1;
            blev   = $urandom_range(0, 1) == 1;
            estop  = $urandom_range(0, 1) == 1;
            spress = $urandom_range(0, 1) == 1;
        end
        return pack_tick(rise, blev, estop, spress, sdial, ddial);
    endfunction

    // one tick transfer after a random gap
    task automatic send_tick(logic [IN_DATA_W-1:0] d);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        repeat (gap) begin
            @(negedge clk);
            s_valid <= 1'b0;
        end
        @(negedge clk);
        s_valid <= 1'b1;
        s_data  <= d;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        sb.note_tick(d);
    endtask

    task automatic tick(logic rise, logic blev, logic estop, logic spress,
                        int sdial, int ddial);
        send_tick(pack_tick(rise, blev, estop, spress, DIAL_W'(sdial), DIAL_W'(ddial)));
    endtask

    task automatic stop_source();
        @(negedge clk);
        s_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.expected_status.size() != 0) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, int value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= CFG_DATA_W'(value);
    endtask

    // all four registers, only called with the block idle
    task automatic write_cfg(int md, int ht, int rs, int pt);
        cfg_write(REG_RET_FLOOR, md);
        cfg_write(REG_HOME_THRESHOLD, ht);
        cfg_write(REG_RETREAT_DUTY, rs);
        cfg_write(REG_PAUSE_TICKS, pt);
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.min_dist     = DIST_W'(md);
        sb.home_thr     = DIST_W'(ht);
        sb.retreat_duty = SPEED_W'(rs);
        sb.pause_len    = TIMER_W'(pt);
        n_settings++;
    endtask

    task automatic run_phase(int md, int ht, int rs, int pt, int n_items,
                             int gap_max, int stall_max);
        drain();
        write_cfg(md, ht, rs, pt);
        src_gap_max    = gap_max;
        sink_stall_max = stall_max;
        repeat (n_items) send_tick(next_tick());
        stop_source();
    endtask

    // run limit
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        sb = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset register values, dial extremes latched in idle
        tick(0, 0, 0, 0, 1023, 1023);
        tick(1, 0, 0, 0, 0, 0);
        tick(1, 1, 0, 0, 512, 512);
        stop_source();
        drain();
        write_cfg(3, 1, 255, 2);

        // both presses in idle, sample ignored in wait, e-stop back to idle, then a sample start
        tick(0, 0, 1, 1, 1023, 3);
        tick(0, 0, 0, 1, 0, 0);
        tick(0, 0, 1, 0, 0, 0);
        tick(0, 0, 0, 1, 1023, 2);
        // forward past the distance, return with an ignored sample press, both presses in wait
        tick(1, 1, 0, 0, 0, 0);
        tick(1, 1, 0, 0, 0, 0);
        tick(1, 0, 0, 1, 0, 0);
        tick(0, 0, 1, 0, 0, 0);
        tick(0, 0, 1, 1, 0, 0);
        // e-stop in forward, then ignored e-stops in pause and retreat
        tick(0, 0, 1, 0, 0, 0);
        tick(0, 0, 0, 0, 0, 0);
        tick(0, 0, 1, 0, 0, 0);
        tick(0, 0, 0, 0, 0, 0);
        tick(0, 0, 1, 0, 0, 0);
        tick(0, 0, 0, 0, 0, 0);
        tick(1, 0, 0, 0, 0, 0);
        // e-stop during return
        tick(0, 0, 1, 0, 0, 0);
        tick(0, 0, 0, 1, 1023, 0);
        tick(1, 1, 0, 0, 0, 0);
        tick(0, 0, 1, 0, 0, 0);
        tick(0, 0, 0, 0, 0, 0);
        tick(0, 0, 0, 0, 0, 0);
        tick(0, 0, 0, 0, 0, 0);
        tick(1, 0, 0, 0, 0, 0);
        stop_source();

        // random sample cycles under several settings
        run_phase(10, 5, 70, 3, 120, 6, 6);
        run_phase(0, 0, 0, 0, 120, 6, 6);
        run_phase(1023, 1023, 255, 1, 100, 0, 0);
        run_phase(20, 0, 128, 6, 120, 6, 0);
        run_phase($urandom_range(0, 30), $urandom_range(0, 30), $urandom_range(0, 255),
                  $urandom_range(0, 8), 120, 0, 6);
        run_phase($urandom_range(0, 30), $urandom_range(0, 30), $urandom_range(0, 255),
                  $urandom_range(0, 8), 120, 6, 6);
        run_phase(4, 2, 200, 1023, 224, 3, 3);

        drain();
        repeat (8) @(posedge clk);

        $display("Covered %0d tick transfers under %0d register settings, %0d results compared",
                 sb.ticks, n_settings, sb.compared);
        $display("E-stops during sampling: %0d, emergency retreats completed: %0d",
                 sb.estop_stops, sb.retreats_done);
        if (sb.errors == 0 && sb.expected_status.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/acsc_pkg.sv
sv/acsc_scale.sv
sv/acsc_step.sv
sv/actuator_sample_cycle_controller_unit.sv
bench/tb_actuator_sample_cycle_controller_unit.sv
